FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define APSP_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define APSP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: src/apsp_pkg.sv
// Shared types and constants for the all-pairs shortest path block.
`default_nettype none

package apsp_pkg;

   localparam int DIST_W = 24;

   typedef logic [DIST_W-1:0] dist_type;

   localparam dist_type DIST_UNREACH = 24'hFFFFFF;
   localparam dist_type DIST_MAXVAL  = 24'hFFFFFE;

   localparam logic [6:0] NODE_COUNT_RST = 7'd64;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_SOLVE = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   // Relaxation verdict: write back value when upd is set.
   typedef struct packed {
      logic     upd;
      dist_type value;
   } relax_type;

endpackage

`default_nettype wire

FILE: src/apsp_relax.sv
// Shared relaxation unit: saturating add and compare against the current entry.
`default_nettype none

module apsp_relax (
   input  apsp_pkg::dist_type  ak,
   input  apsp_pkg::dist_type  kb,
   input  apsp_pkg::dist_type  ab,
   output apsp_pkg::relax_type result
);
   import apsp_pkg::*;

   logic [DIST_W:0] sum;
   dist_type        sat;

   always_comb begin
      sum = {1'b0, ak} + {1'b0, kb};
      // clamp one below the unreachable mark
      if (sum > {1'b0, DIST_MAXVAL}) begin
         sat = DIST_MAXVAL;
      end else begin
         sat = sum[DIST_W-1:0];
      end
      result.upd   = (kb != DIST_UNREACH) && (sat < ab);
      result.value = sat;
   end

endmodule

`default_nettype wire

FILE: src/apsp_table.sv
// Distance table memory: one write port, two registered read ports.
`default_nettype none

module apsp_table #(
   parameter int AW = 12
) (
   input  logic               clock,
   input  logic               we,
   input  logic [AW-1:0]      waddr,
   input  apsp_pkg::dist_type wdata,
   input  logic [AW-1:0]      ra_addr,
   output apsp_pkg::dist_type ra_data,
   input  logic [AW-1:0]      rb_addr,
   output apsp_pkg::dist_type rb_data
);
   import apsp_pkg::*;

   localparam int DEPTH = 1 << AW;

   dist_type mem [DEPTH];
   dist_type ra_data_ff;
   dist_type rb_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      ra_data_ff <= mem[ra_addr];
      rb_data_ff <= mem[rb_addr];
   end

   assign ra_data = ra_data_ff;
   assign rb_data = rb_data_ff;

endmodule

`default_nettype wire

FILE: src/all_pairs_shortest_path.sv
// Top level: Floyd-Warshall all-pairs shortest path engine with table and sequencer.
//
//  channel  dir  handshake              payload
//  req_     in   req_valid/req_ready    req_mode, req_src_node, req_dst_node, req_edge_cost
//  rsp_     out  rsp_valid/rsp_ready    rsp_distance, rsp_unreachable
//  csr_     in   csr_wr_en (no wait)    csr_wr_data (node_count)
//
// Per transaction:
//   add edge writes the table when accepted, query waits on the registered table read,
//   clear writes one table entry per cycle across the whole table,
//   solve: per (k, a) pair one read of a->k, then, if it is reachable, one
//   column per cycle through the shared relax unit and a drain step.
// The table has a single write port; that port paces clear and solve.
// Reset is synchronous: sequencer idle, no response pending, node_count = 64.
//   The table itself is not cleared by reset; a clear transaction does that.
// A new request is taken only in idle with the response slot free or draining;
//   a stalled rsp_ready holds the result and blocks the next request.
`default_nettype none

`include "assert_macros.svh"

module all_pairs_shortest_path #(
   parameter int MAX_NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_src_node,
   input  logic [5:0]  req_dst_node,
   input  logic [15:0] req_edge_cost,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_distance,
   output logic        rsp_unreachable,
   // configuration
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import apsp_pkg::*;

   // widths derived from the node capacity
   localparam int NW = $clog2(MAX_NODES + 1);   // holds a node count
   localparam int IW = $clog2(MAX_NODES);       // holds a node index
   localparam int AW = 2 * IW;                  // table address {row, col}
   localparam int CW = (NW > 7) ? NW : 7;       // count compare width
   localparam int SW = (NW > 6) ? NW : 6;       // index compare width

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_QUERY,
      S_AK_RD,
      S_AK,
      S_COL,
      S_DRAIN
   } state_type;

   // registers
   state_type     state_ff,        state_in;
   logic [6:0]    node_count_ff,   node_count_in;
   logic [IW-1:0] k_ff,            k_in;
   logic [IW-1:0] a_ff,            a_in;
   logic [IW-1:0] b_ff,            b_in;
   logic [IW-1:0] wcol_ff,         wcol_in;
   logic          col_vld_ff,      col_vld_in;
   dist_type      ak_ff,           ak_in;
   logic [AW-1:0] clr_ff,          clr_in;
   logic          q_ok_ff,         q_ok_in;
   logic          rsp_valid_ff,    rsp_valid_in;
   dist_type      rsp_distance_ff, rsp_distance_in;
   logic          rsp_unreach_ff,  rsp_unreach_in;

   // combinational
   logic [CW-1:0] cnt_ext;
   logic [NW-1:0] n_eff;
   logic [IW-1:0] n_last;
   logic          req_accept;
   logic          src_ok;
   logic          dst_ok;
   logic [IW-1:0] src_idx;
   logic [IW-1:0] dst_idx;
   logic          row_done;
   logic          rsp_load;
   dist_type      rsp_dist_new;
   logic          rsp_unr_new;

   // table ports
   logic          tbl_we;
   logic [AW-1:0] tbl_waddr;
   dist_type      tbl_wdata;
   logic [AW-1:0] tbl_ra_addr;
   dist_type      tbl_ra_data;
   logic [AW-1:0] tbl_rb_addr;
   dist_type      tbl_rb_data;
   relax_type     relax;

   apsp_table #(
      .AW (AW)
   ) u_table (
      .clock   (clock),
      .we      (tbl_we),
      .waddr   (tbl_waddr),
      .wdata   (tbl_wdata),
      .ra_addr (tbl_ra_addr),
      .ra_data (tbl_ra_data),
      .rb_addr (tbl_rb_addr),
      .rb_data (tbl_rb_data)
   );

   // During columns: port A returns a->b, port B returns k->b.
   apsp_relax u_relax (
      .ak     (ak_ff),
      .kb     (tbl_rb_data),
      .ab     (tbl_ra_data),
      .result (relax)
   );

   // Effective node count: zero acts as one, beyond capacity clamps.
   always_comb begin
      cnt_ext = CW'(node_count_ff);
      if (cnt_ext == '0) begin
         n_eff = NW'(1);
      end else if (cnt_ext > CW'(MAX_NODES)) begin
         n_eff = NW'(MAX_NODES);
      end else begin
         n_eff = NW'(cnt_ext);
      end
   end

   assign n_last     = IW'(n_eff - NW'(1));
   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign src_ok     = SW'(req_src_node) < SW'(n_eff);
   assign dst_ok     = SW'(req_dst_node) < SW'(n_eff);
   assign src_idx    = IW'(req_src_node);
   assign dst_idx    = IW'(req_dst_node);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      k_in          = k_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      wcol_in       = wcol_ff;
      col_vld_in    = 1'b0;
      ak_in         = ak_ff;
      clr_in        = clr_ff;
      q_ok_in       = q_ok_ff;
      row_done      = 1'b0;
      rsp_load      = 1'b0;
      rsp_dist_new  = '0;
      rsp_unr_new   = 1'b0;
      tbl_we        = 1'b0;
      tbl_waddr     = '0;
      tbl_wdata     = '0;
      tbl_ra_addr   = {a_ff, k_ff};
      tbl_rb_addr   = {k_ff, b_ff};

      // write-back stage of the relax pipe; a_ff is still this row
      if (col_vld_ff && relax.upd) begin
         tbl_we    = 1'b1;
         tbl_waddr = {a_ff, wcol_ff};
         tbl_wdata = relax.value;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (mode_type'(req_mode))
                  MODE_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  MODE_ADD: begin
                     if (src_ok && dst_ok) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = {src_idx, dst_idx};
                        tbl_wdata = DIST_W'(req_edge_cost);
                     end
                     rsp_load = 1'b1;
                  end
                  MODE_SOLVE: begin
                     k_in     = '0;
                     a_in     = '0;
                     state_in = S_AK_RD;
                  end
                  MODE_QUERY: begin
                     tbl_ra_addr = {src_idx, dst_idx};
                     q_ok_in     = src_ok && dst_ok;
                     state_in    = S_QUERY;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            tbl_wdata = (clr_ff[AW-1:IW] == clr_ff[IW-1:0]) ? '0 : DIST_UNREACH;
            clr_in    = clr_ff + AW'(1);
            if (&clr_ff) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_QUERY: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
            if (!q_ok_ff || (tbl_ra_data == DIST_UNREACH)) begin
               rsp_unr_new = 1'b1;
            end else begin
               rsp_dist_new = tbl_ra_data;
            end
         end
         S_AK_RD: begin
            state_in = S_AK;
         end
         S_AK: begin
            ak_in = tbl_ra_data;
            if (tbl_ra_data == DIST_UNREACH) begin
               row_done = 1'b1;
            end else begin
               b_in     = '0;
               state_in = S_COL;
            end
         end
         S_COL: begin
            tbl_ra_addr = {a_ff, b_ff};
            tbl_rb_addr = {k_ff, b_ff};
            col_vld_in  = 1'b1;
            wcol_in     = b_ff;
            if (b_ff == n_last) begin
               state_in = S_DRAIN;
            end else begin
               b_in = b_ff + IW'(1);
            end
         end
         S_DRAIN: begin
            row_done = 1'b1;
         end
      endcase

      // Row finished: next source row, next intermediate, or done.
      if (row_done) begin
         if (a_ff == n_last) begin
            if (k_ff == n_last) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + IW'(1);
               a_in     = '0;
               state_in = S_AK_RD;
            end
         end else begin
            a_in     = a_ff + IW'(1);
            state_in = S_AK_RD;
         end
      end

      // Response register; a load only happens with the slot free or draining.
      rsp_valid_in    = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_distance_in = rsp_load ? rsp_dist_new : rsp_distance_ff;
      rsp_unreach_in  = rsp_load ? rsp_unr_new : rsp_unreach_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_RST;
         col_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         col_vld_ff    <= col_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      k_ff            <= k_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      wcol_ff         <= wcol_in;
      ak_ff           <= ak_in;
      clr_ff          <= clr_in;
      q_ok_ff         <= q_ok_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_unreach_ff  <= rsp_unreach_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_distance_ff;
   assign rsp_unreachable = rsp_unreach_ff;

   // A new result never overwrites one still waiting.
   `APSP_ASSERT_SAME(a_rsp_no_overwrite, clock, reset, rsp_load && rsp_valid_ff, rsp_ready, "response overwritten")
   // Relax write-back only while walking a row.
   `APSP_ASSERT_SAME(a_relax_in_row, clock, reset, col_vld_ff, (state_ff == S_COL) || (state_ff == S_DRAIN), "relax write outside row")
   // Columns are only walked for a reachable a->k.
   `APSP_ASSERT_SAME(a_ak_reachable, clock, reset, state_ff == S_COL, ak_ff != DIST_UNREACH, "column walk with unreachable pivot")
   // End of the clear sweep produces the response.
   `APSP_ASSERT_NEXT(a_clear_done, clock, reset, (state_ff == S_CLEAR) && (&clr_ff), rsp_valid_ff && (state_ff == S_IDLE), "clear did not complete")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the all-pairs shortest path block.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import apsp_pkg::*;

   localparam int NODES = 64;
   // Slowest legal run is dominated by the one full-size solve and the clear
   // sweeps; allow several times that.
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int ITEM_TARGET = 950;

   typedef struct packed {
      mode_type    mode;
      logic [5:0]  src;
      logic [5:0]  dst;
      logic [15:0] cost;
   } request_t;

   typedef struct packed {
      dist_type distance;
      logic     unreachable;
   } answer_t;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_CLEAR;
   logic [5:0]  req_src_node = '0;
   logic [5:0]  req_dst_node = '0;
   logic [15:0] req_edge_cost = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_distance;
   logic        rsp_unreachable;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   all_pairs_shortest_path #(.MAX_NODES(NODES)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_src_node    (req_src_node),
      .req_dst_node    (req_dst_node),
      .req_edge_cost   (req_edge_cost),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance    (rsp_distance),
      .rsp_unreachable (rsp_unreachable),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow state of the block: distance table and node_count register
   // ---------------------------------------------------------------------
   dist_type   shadow_dist [NODES*NODES];
   logic [6:0] node_cfg = NODE_COUNT_RST;

   request_t requests_waiting [$];   // stimulus not yet presented
   answer_t  answers_due [$];        // predicted results, oldest first
   int       error_count = 0;
   int       items_sent = 0;
   bit       no_idle = 1'b0;         // set per session: both sides run flat out

   // node_count zero behaves as one node, anything past the table size as full size
   function automatic int eff_nodes();
      if (node_cfg == 0) return 1;
      if (node_cfg > NODES) return NODES;
      return int'(node_cfg);
   endfunction

   // Floyd-Warshall over the active corner of the table. Unreachable never
   // takes part in a sum; a sum of two reachable entries clamps below the mark.
   function automatic void relax_through_all(int n);
      dist_type    via_k;
      dist_type    from_k;
      logic [24:0] sum;
      for (int k = 0; k < n; k++) begin
         for (int a = 0; a < n; a++) begin
            via_k = shadow_dist[a*NODES + k];
            if (via_k != DIST_UNREACH) begin
               for (int b = 0; b < n; b++) begin
                  from_k = shadow_dist[k*NODES + b];
                  if (from_k != DIST_UNREACH) begin
                     sum = {1'b0, via_k} + {1'b0, from_k};
                     if (sum > {1'b0, DIST_MAXVAL}) sum = {1'b0, DIST_MAXVAL};
                     if (sum[23:0] < shadow_dist[a*NODES + b])
                        shadow_dist[a*NODES + b] = sum[23:0];
                  end
               end
            end
         end
      end
   endfunction

   // Applies one accepted transaction to the shadow table and returns its result.
   function automatic answer_t answer_request(request_t r);
      answer_t ans;
      int      n;
      dist_type v;
      n = eff_nodes();
      ans = '0;
      case (r.mode)
         MODE_CLEAR: begin
            for (int i = 0; i < NODES*NODES; i++) shadow_dist[i] = DIST_UNREACH;
            for (int i = 0; i < NODES; i++) shadow_dist[i*NODES + i] = '0;
         end
         MODE_ADD: begin
            // out-of-range endpoints: edge silently dropped
            if (r.src < n && r.dst < n) shadow_dist[r.src*NODES + r.dst] = dist_type'(r.cost);
         end
         MODE_SOLVE: begin
            relax_through_all(n);
         end
         default: begin
            if (r.src < n && r.dst < n) begin
               v = shadow_dist[r.src*NODES + r.dst];
               if (v == DIST_UNREACH) ans.unreachable = 1'b1;
               else ans.distance = v;
            end else begin
               ans.unreachable = 1'b1;
            end
         end
      endcase
      return ans;
   endfunction

   // Mostly short gaps, some medium, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued requests, predicts on each accepted transaction.
   // Exactly one NBA per signal per edge, so valid never glitches low between
   // back-to-back transactions.
   // ---------------------------------------------------------------------
   request_t    on_wire;
   int unsigned req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) answers_due.push_back(answer_request(on_wire));
         if (!(req_valid && !req_ready)) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (requests_waiting.size() != 0) begin
               on_wire = requests_waiting.pop_front();
               req_mode      <= on_wire.mode;
               req_src_node  <= on_wire.src;
               req_dst_node  <= on_wire.dst;
               req_edge_cost <= on_wire.cost;
               req_valid     <= 1'b1;
               req_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random backpressure; each result checked against the oldest
   // prediction, field by field.
   // ---------------------------------------------------------------------
   int unsigned rsp_gap = 0;
   answer_t     want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual distance %0d unreachable %0b",
                        $time, rsp_distance, rsp_unreachable);
               error_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_distance !== want.distance) begin
                  $display("%0t: distance mismatch, expected %0d, actual %0d",
                           $time, want.distance, rsp_distance);
                  error_count++;
               end
               if (rsp_unreachable !== want.unreachable) begin
                  $display("%0t: unreachable mismatch, expected %0b, actual %0b",
                           $time, want.unreachable, rsp_unreachable);
                  error_count++;
               end
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // Watchdog
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_req(mode_type m, int s, int d, int c);
      request_t r;
      r.mode = m;
      r.src  = 6'(s);
      r.dst  = 6'(d);
      r.cost = 16'(c);
      requests_waiting.push_back(r);
      items_sent++;
   endtask

   // Mostly in-range nodes; the rest spans the whole 6-bit field.
   function automatic int pick_node(int n);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, n - 1);
   endfunction

   function automatic int pick_cost();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 16'hFFFF;
      if (r < 6) return $urandom_range(1, 20);
      return $urandom_range(0, 65535);
   endfunction

   // Sender holds off until every predicted result has been collected.
   task automatic wait_drained();
      do @(negedge clock);
      while (requests_waiting.size() != 0 || req_valid || answers_due.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic set_node_count(logic [6:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      node_cfg = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One graph session: clear, load edges, solve (when asked), query. Some sessions add
   // edges after the solve and re-solve, or clear again and query; ignored fields of
   // the first clear and solve carry random junk.
   task automatic queue_session(bit solve_it);
      int n;
      int lim;
      n = eff_nodes();
      lim = (n > 12) ? 12 : n;
      push_req(MODE_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535));
      repeat ($urandom_range(lim, 3*lim + 4)) begin
         if ($urandom_range(0, 5) == 0)
            push_req(MODE_QUERY, pick_node(n), pick_node(n), $urandom_range(0, 65535));
         else
            push_req(MODE_ADD, pick_node(n), pick_node(n), pick_cost());
      end
      if (solve_it)
         push_req(MODE_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 65535));
      repeat ($urandom_range(10, 2*lim + 16))
         push_req(MODE_QUERY, pick_node(n), pick_node(n), $urandom_range(0, 65535));
      if (solve_it && $urandom_range(0, 3) == 0) begin
         // new edges after a solve are not relaxed until the next solve
         repeat ($urandom_range(1, lim + 2)) push_req(MODE_ADD, pick_node(n), pick_node(n), pick_cost());
         repeat (4) push_req(MODE_QUERY, pick_node(n), pick_node(n), 0);
         push_req(MODE_SOLVE, 0, 0, 0);
         repeat (lim + 4) push_req(MODE_QUERY, pick_node(n), pick_node(n), 0);
      end
      if ($urandom_range(0, 9) == 0) begin
         push_req(MODE_CLEAR, 0, 0, 0);
         repeat (6) push_req(MODE_QUERY, pick_node(n), pick_node(n), 0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   logic [6:0] fixed_counts [6] = '{7'd1, 7'd0, 7'd2, 7'd127, 7'd65, 7'd3};

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset node count of 64. First transaction is a
      // clear, so nothing ever reads a table entry that was never written.
      push_req(MODE_CLEAR, 63, 63, 16'hFFFF);
      push_req(MODE_QUERY, 0, 0, 0);
      push_req(MODE_QUERY, 63, 63, 0);
      push_req(MODE_QUERY, 0, 63, 0);
      push_req(MODE_QUERY, 63, 0, 0);
      push_req(MODE_ADD, 0, 1, 0);
      push_req(MODE_ADD, 1, 63, 16'hFFFF);
      push_req(MODE_ADD, 63, 0, 16'hFFFF);
      push_req(MODE_ADD, 5, 5, 7);              // edge on the diagonal
      push_req(MODE_ADD, 2, 3, 1234);
      push_req(MODE_QUERY, 5, 5, 0);
      push_req(MODE_QUERY, 0, 1, 0);
      push_req(MODE_QUERY, 1, 0, 0);            // not yet relaxed
      push_req(MODE_SOLVE, 0, 0, 0);            // one full-size solve
      push_req(MODE_QUERY, 0, 63, 0);
      push_req(MODE_QUERY, 63, 1, 0);
      push_req(MODE_QUERY, 1, 0, 0);            // two max-cost hops
      push_req(MODE_QUERY, 1, 1, 0);            // cycle does not beat zero
      push_req(MODE_QUERY, 5, 5, 0);
      push_req(MODE_QUERY, 2, 3, 0);
      push_req(MODE_QUERY, 3, 2, 0);
      push_req(MODE_QUERY, 0, 2, 0);
      wait_drained();

      // Fixed settings: single node, zero (acts as one), two, two values past the
      // table size (act as 64; solve skipped there for run time), and three.
      foreach (fixed_counts[i]) begin
         no_idle = ($urandom_range(0, 3) == 0);
         set_node_count(fixed_counts[i]);
         queue_session(fixed_counts[i] <= 7'd12);
         wait_drained();
      end

      // Random sessions, small graphs so solves stay cheap.
      while (items_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 3) == 0);
         set_node_count(($urandom_range(0, 9) == 0) ? 7'd1 : 7'($urandom_range(2, 12)));
         queue_session(1'b1);
         wait_drained();
      end

      // Block is drained; keep clocking to catch any stray result.
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
